/* hw/rtl/wpm_pkg.sv */
package wpm_pkg;

	// Depth of the pattern store, in bytes.
	localparam int MAX_PATTERN = 32;
	// Active-position vector covers positions 0..MAX_PATTERN.
	localparam int POS_W = MAX_PATTERN + 1;
	// Length counter must hold MAX_PATTERN itself.
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	// Index into the pattern store.
	localparam int IDX_W = $clog2(MAX_PATTERN);
	// Levels of the parallel-prefix star closure.
	localparam int CL_LEVELS = $clog2(POS_W);

	localparam logic [7:0] SYM_STAR = 8'h2A;
	localparam logic [7:0] SYM_ONE  = 8'h3F;

	typedef enum logic [1:0] {
		CMD_PATTERN = 2'd0,
		CMD_TEXT    = 2'd1,
		CMD_END     = 2'd2
	} cmd_t;

	// What the pattern store shows of the current pattern, per position.
	typedef struct packed {
		logic [MAX_PATTERN-1:0] valid;    // position lies inside the pattern
		logic [MAX_PATTERN-1:0] star;     // valid and holds '*'
		logic [MAX_PATTERN-1:0] one;      // valid and holds '?'
		logic [MAX_PATTERN-1:0] eq;       // stored byte equals the text byte
		logic [LEN_W-1:0]       len;
		logic                   overflow;
	} pat_view_t;

	// Controls from the top level to the active-vector unit.
	typedef struct packed {
		logic step;     // advance by one text byte
		logic rearm;    // restart at position zero
	} nfa_ctl_t;

	// An active '*' at position i also activates position i+1, repeatedly
	// through runs of stars. Done as a log-depth prefix: generate is the
	// active bit, propagate into position j is "position j-1 is a star".
	function automatic logic [POS_W-1:0] star_closure(
		input logic [POS_W-1:0]       act,
		input logic [MAX_PATTERN-1:0] star
	);
		logic [POS_W-1:0] g;
		logic [POS_W-1:0] p;
		g = act;
		p = {star, 1'b0};
		for (int lvl = 0; lvl < CL_LEVELS; lvl++) begin
			g = g | (p & (g << (1 << lvl)));
			p = p & (p << (1 << lvl));
		end
		return g;
	endfunction

endpackage

/* hw/rtl/wpm_pattern_store.sv */
module wpm_pattern_store
	import wpm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [7:0] wr_sym,
	input  logic       wr_last,
	input  logic [7:0] txt_sym,
	output pat_view_t  view
);

	logic [7:0]             byte_q [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] valid_q;
	logic [LEN_W-1:0]       len_q;
	logic                   ovf_q;
	logic                   complete_q;

	logic [MAX_PATTERN-1:0] base_valid;
	logic [LEN_W-1:0]       base_len;
	logic                   base_ovf;
	logic                   room;

	// A byte arriving after a finished pattern starts a new one.
	assign base_valid = complete_q ? '0 : valid_q;
	assign base_len   = complete_q ? '0 : len_q;
	assign base_ovf   = complete_q ? 1'b0 : ovf_q;
	assign room       = base_len < LEN_W'(MAX_PATTERN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			len_q      <= '0;
			ovf_q      <= 1'b0;
			complete_q <= 1'b1;
		end else if (wr_en) begin
			complete_q <= wr_last;
			if (room) begin
				valid_q <= base_valid | (MAX_PATTERN'(1) << base_len[IDX_W-1:0]);
				len_q   <= base_len + LEN_W'(1);
				ovf_q   <= base_ovf;
			end else begin
				valid_q <= base_valid;
				len_q   <= base_len;
				ovf_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && room) begin
			byte_q[base_len[IDX_W-1:0]] <= wr_sym;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			view.valid[i] = valid_q[i];
			view.star[i]  = valid_q[i] && (byte_q[i] == SYM_STAR);
			view.one[i]   = valid_q[i] && (byte_q[i] == SYM_ONE);
			view.eq[i]    = byte_q[i] == txt_sym;
		end
		view.len      = len_q;
		view.overflow = ovf_q;
	end

endmodule

/* hw/rtl/wpm_nfa.sv */
module wpm_nfa
	import wpm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  nfa_ctl_t  ctl,
	input  pat_view_t view,
	output logic      hit
);

	// Positions reached so far, kept before star closure; the closure is
	// applied on use against the pattern as it stands.
	logic [POS_W-1:0]       raw_q;
	logic [POS_W-1:0]       act;
	logic [MAX_PATTERN-1:0] lit_act;
	logic [MAX_PATTERN-1:0] adv;
	logic [MAX_PATTERN-1:0] stay;
	logic [POS_W-1:0]       next_raw;

	assign act      = star_closure(raw_q, view.star);
	assign lit_act  = act[MAX_PATTERN-1:0] & view.valid & ~view.star;
	assign adv      = lit_act & (view.one | view.eq);
	assign stay     = act[MAX_PATTERN-1:0] & view.star;
	assign next_raw = {adv, 1'b0} | {1'b0, stay};

	assign hit = (view.len != '0) && !view.overflow && act[view.len];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= POS_W'(1);
		end else if (ctl.rearm) begin
			raw_q <= POS_W'(1);
		end else if (ctl.step) begin
			raw_q <= next_raw;
		end
	end

endmodule

/* hw/rtl/wildcard_pattern_matcher.sv */
// Whole-text wildcard matcher. Each input item carries a command in s_tuser:
// a pattern byte (s_tlast marks the final one, and the next pattern byte
// then starts a new pattern), a text byte, or an end-of-text request. In a
// pattern '*' matches any run of bytes, including none, and '?' exactly one
// byte. Only the end-of-text item produces a result: m_tdata bit 0 says
// whether the text since the last rearm matched the whole pattern, m_tuser
// says the pattern was longer than the store (then the match is always 0).
// An empty pattern never matches. Any pattern byte, and every end-of-text
// item, restarts the text. The block takes one item every clock cycle while
// no end-of-text item is stalled. That rate is set by the active-position
// vector, which is read, advanced by one byte with star closure, and written
// back in the same cycle, so each item must see the vector its predecessor
// left. An end-of-text item passes through the input register and then, when
// the result register is free, into the result register, from which its
// result is presented. Input backpressure comes only from an end-of-text
// item that finds the result register still occupied. No clearing pass is
// needed after reset.
module wildcard_pattern_matcher
	import wpm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] symbol
	input  logic [1:0] s_tuser,    // [1:0] command
	input  logic       s_tlast,    // last pattern byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [0] matched, [7:1] zero
	output logic       m_tuser     // [0] pattern_overflow
);

	// Input register stage.
	logic       valid_s1;
	cmd_t       cmd_s1;
	logic [7:0] sym_s1;
	logic       last_s1;

	// Result register.
	logic out_valid_q;
	logic matched_q;
	logic ovf_q;

	logic      stall;
	logic      advance;
	logic      is_pat;
	logic      is_end;
	nfa_ctl_t  ctl;
	pat_view_t view;
	logic      hit;

	// Only an end-of-text item needs the result register to be free.
	assign stall    = valid_s1 && (cmd_s1 == CMD_END) && out_valid_q && !m_tready;
	assign advance  = valid_s1 && !stall;
	assign s_tready = !valid_s1 || !stall;

	always_comb begin
		is_pat   = 1'b0;
		is_end   = 1'b0;
		ctl.step = 1'b0;
		unique case (cmd_s1)
			CMD_PATTERN: is_pat   = 1'b1;
			CMD_TEXT:    ctl.step = advance;
			CMD_END:     is_end   = 1'b1;
			default: begin
				// The unused command code is consumed and does nothing.
			end
		endcase
		ctl.rearm = advance && (is_pat || is_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= cmd_t'(s_tuser);
			sym_s1  <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	wpm_pattern_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (advance && is_pat),
		.wr_sym  (sym_s1),
		.wr_last (last_s1),
		.txt_sym (sym_s1),
		.view    (view)
	);

	wpm_nfa u_nfa (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.view   (view),
		.hit    (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_end) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_end) begin
			matched_q <= hit;
			ovf_q     <= view.overflow;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, matched_q};
	assign m_tuser  = ovf_q;

endmodule

/* hw/rtl/wpm_checker.sv */
module wpm_checker
	import wpm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic [1:0] s_tuser,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser
);

	// A waiting result holds still until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// An overflowed pattern never reports a match.
	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[0])
		else $error("match reported with pattern overflow");

	// A fresh result follows an accepted end-of-text item.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == CMD_END), 2))
		else $error("result without an end-of-text item");

	// Padding bits of the result are always zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:1] == 7'd0)
		else $error("result padding not zero");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (.*);
